### src/rtp_pkg.sv
// Package for the region translate and permit unit.
// Holds the word types, action and status codes and the sequencer states.
// No dependencies.
package rtp_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_MAP   = 2'd0,
    ACT_LOAD_ARENA = 2'd1,
    ACT_TRANSLATE  = 2'd2,
    ACT_PAYLOAD    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_ALIGN  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  entry_slot;
    logic [63:0] address;
    logic [63:0] size;
    logic [1:0]  rights;
    logic [63:0] local_base;
    logic [31:0] queue_number;
    logic        index_access;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] local_address;
    logic [2:0]  hit_slot;
  } out_word_t;

  // Inputs to the shared range compare unit.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] alen;
    logic [63:0] b;
    logic [63:0] blen;
  } cmp_req_t;

  typedef struct packed {
    logic        covered;
    logic [63:0] offset;
  } cmp_rsp_t;

endpackage

### src/rtp_range_cmp.sv
// Shared range compare unit: tests whether [a, a+alen) lies in [b, b+blen).
// Uses rtp_pkg. Purely combinational; one table entry is compared per cycle.
module rtp_range_cmp
  import rtp_pkg::*;
(
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  logic [63:0] off;

  // The offset test avoids forming a + alen, so no end can overflow here.
  assign off = req_i.a - req_i.b;
  assign rsp_o.offset = off;
  assign rsp_o.covered = (req_i.a >= req_i.b) && (off <= req_i.blen) &&
                         (req_i.alen <= req_i.blen - off);

endmodule

### src/region_translate_and_permit_unit.sv
// Region translate and permit unit: mapping and arena tables with a scanning sequencer.
// A mapping load needs no table scan; arena loads and translates scan the mapping table and
// payload checks scan the arena table, the single range compare unit visiting one table
// entry per cycle. One word at a time.
// Reset clears the valid bits and the sequencer; table contents are undefined until loaded.
module region_translate_and_permit_unit
  import rtp_pkg::*;
#(
  parameter int MAP_ENTRIES   = 8,
  parameter int ARENA_ENTRIES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int AW = (ARENA_ENTRIES > 1) ? $clog2(ARENA_ENTRIES) : 1;
  localparam int CW = ((MW > AW) ? MW : AW) + 1;
  localparam logic [63:0] MaxU = '1;

  logic [63:0] map_base_q   [MAP_ENTRIES];
  logic [63:0] map_length_q [MAP_ENTRIES];
  logic [63:0] map_local_q  [MAP_ENTRIES];
  logic [1:0]  map_rights_q [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] map_valid_q;
  logic [63:0] arena_base_q   [ARENA_ENTRIES];
  logic [63:0] arena_length_q [ARENA_ENTRIES];
  logic [31:0] arena_queue_q  [ARENA_ENTRIES];
  logic [1:0]  arena_rights_q [ARENA_ENTRIES];
  logic [ARENA_ENTRIES-1:0] arena_valid_q;

  seq_state_e state_q, state_d;
  in_word_t   cur_q;
  logic [CW-1:0] idx_q, idx_d;
  out_word_t  res_q, res_d;
  logic       found_q, found_d;
  logic       pre_ok_q;

  cmp_req_t req;
  cmp_rsp_t rsp;
  logic [MW-1:0] mi;
  logic [AW-1:0] ai;
  logic [MW-1:0] wm;
  logic [AW-1:0] wa;
  logic [CW-1:0] last;
  logic entry_ok, scan_end;
  logic [63:0] la;
  logic [63:0] need;
  logic slot_in_map, slot_in_arena;

  rtp_range_cmp u_cmp (.req_i(req), .rsp_o(rsp));

  assign mi = idx_q[MW-1:0];
  assign ai = idx_q[AW-1:0];
  assign wm = MW'(cur_q.entry_slot);
  assign wa = AW'(cur_q.entry_slot);
  assign slot_in_map   = 32'(cur_q.entry_slot) < MAP_ENTRIES;
  assign slot_in_arena = 32'(cur_q.entry_slot) < ARENA_ENTRIES;
  assign need = cur_q.index_access ? 64'd2 : cur_q.size;
  assign la = map_local_q[mi] + rsp.offset;

  always_comb begin
    req = '0;
    entry_ok = 1'b0;
    last = CW'(MAP_ENTRIES - 1);
    case (action_e'(cur_q.action))
      ACT_LOAD_ARENA: begin
        req = '{a: cur_q.address, alen: cur_q.size, b: map_base_q[mi],
                blen: map_length_q[mi]};
        entry_ok = map_valid_q[mi] && rsp.covered;
      end
      ACT_TRANSLATE: begin
        req = '{a: cur_q.address, alen: need, b: map_base_q[mi], blen: map_length_q[mi]};
        entry_ok = map_valid_q[mi] && rsp.covered &&
                   ((map_rights_q[mi] & cur_q.rights) == cur_q.rights);
      end
      ACT_PAYLOAD: begin
        last = CW'(ARENA_ENTRIES - 1);
        req = '{a: cur_q.address, alen: cur_q.size, b: arena_base_q[ai],
                blen: arena_length_q[ai]};
        entry_ok = arena_valid_q[ai] && rsp.covered &&
                   (arena_queue_q[ai] == cur_q.queue_number) &&
                   ((arena_rights_q[ai] & cur_q.rights) == cur_q.rights);
      end
      default: ;
    endcase
  end

  assign scan_end = (idx_q == last);

  // Sequencer: one entry per cycle in S_SCAN, result held in S_DONE.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    res_d   = res_q;
    found_d = found_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
          idx_d   = '0;
          found_d = 1'b0;
          res_d   = '{status: ST_MISS, local_address: '0, hit_slot: '0};
        end
      end
      S_SCAN: begin
        idx_d = idx_q + CW'(1);
        case (action_e'(cur_q.action))
          ACT_LOAD_MAP: begin
            res_d.hit_slot = cur_q.entry_slot;
            res_d.status = (slot_in_map && pre_ok_q) ? ST_OK : ST_REJECT;
            state_d = S_DONE;
          end
          ACT_LOAD_ARENA: begin
            res_d.hit_slot = cur_q.entry_slot;
            if (!found_q && pre_ok_q && entry_ok) found_d = 1'b1;
            if (scan_end || !slot_in_arena || !pre_ok_q) begin
              res_d.status = (slot_in_arena && pre_ok_q && (found_q || entry_ok)) ?
                             ST_OK : ST_REJECT;
              state_d = S_DONE;
            end
          end
          ACT_TRANSLATE: begin
            if (entry_ok) begin
              res_d.hit_slot = 3'(idx_q);
              if (cur_q.index_access && (cur_q.address[0] || la[0])) begin
                res_d.status = ST_ALIGN;
              end else begin
                res_d.status = ST_OK;
                res_d.local_address = la;
              end
              state_d = S_DONE;
            end else if (scan_end) begin
              state_d = S_DONE;
            end
          end
          default: begin
            if (pre_ok_q && entry_ok) begin
              res_d.status = ST_OK;
              res_d.hit_slot = 3'(idx_q);
              state_d = S_DONE;
            end else if (scan_end || !pre_ok_q) begin
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  // Field checks that do not need the tables are taken at acceptance.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && in_valid_i) begin
      cur_q <= in_data_i;
      case (action_e'(in_data_i.action))
        ACT_LOAD_MAP: pre_ok_q <= (in_data_i.size != '0) &&
          (in_data_i.address <= MaxU - in_data_i.size) && (in_data_i.local_base != '0) &&
          (in_data_i.local_base <= MaxU - in_data_i.size) && (in_data_i.rights != '0);
        ACT_LOAD_ARENA: pre_ok_q <= (in_data_i.queue_number != '0) &&
          (in_data_i.size != '0) && (in_data_i.address <= MaxU - in_data_i.size) &&
          (in_data_i.rights != '0);
        ACT_PAYLOAD: pre_ok_q <= (in_data_i.size != '0) &&
          (in_data_i.address <= MaxU - in_data_i.size);
        default: pre_ok_q <= 1'b1;
      endcase
    end
  end

  logic map_wr, arena_wr;
  assign map_wr = (state_q == S_SCAN) && (action_e'(cur_q.action) == ACT_LOAD_MAP) &&
                  slot_in_map;
  assign arena_wr = (state_q == S_SCAN) && (state_d == S_DONE) &&
                    (action_e'(cur_q.action) == ACT_LOAD_ARENA) && slot_in_arena;

  always_ff @(posedge clk_i) begin
    if (map_wr && pre_ok_q) begin
      map_base_q[wm]   <= cur_q.address;
      map_length_q[wm] <= cur_q.size;
      map_local_q[wm]  <= cur_q.local_base;
      map_rights_q[wm] <= cur_q.rights;
    end
    if (arena_wr && res_d.status == ST_OK) begin
      arena_base_q[wa]   <= cur_q.address;
      arena_length_q[wa] <= cur_q.size;
      arena_queue_q[wa]  <= cur_q.queue_number;
      arena_rights_q[wa] <= cur_q.rights;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q   <= '0;
      arena_valid_q <= '0;
    end else begin
      if (map_wr) map_valid_q[wm] <= pre_ok_q;
      if (arena_wr) arena_valid_q[wa] <= (res_d.status == ST_OK);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_data_o  = res_q;

endmodule

### src/rtp_checker.sv
// Port-level checker for the region translate and permit unit, with its bind.
// Uses rtp_pkg for the word types and status codes.
module rtp_checker
  import rtp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // Input and output sides never overlap: one word at a time.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed");

  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.local_address == '0))
    else $error("address on failure");

endmodule

bind region_translate_and_permit_unit rtp_checker u_rtp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
